>>> hw/rtl/bsc_pkg.sv
// Shared types and constants for the barometric sensor compensation pipeline.
package bsc_pkg;

  localparam int REG_COUNT = 5;
  localparam int ADDR_W    = 5;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [23:0] raw_press;
    logic [1:0]  oversampling;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic signed [31:0] pressure;
    logic               div_error;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
  } cal_t;

  localparam logic signed [31:0] TEMP_OFFSET = 32'sd4000;
  localparam logic [31:0]        B4_BIAS     = 32'd32768;
  localparam logic [31:0]        B7_SCALE    = 32'd50000;
  localparam logic signed [31:0] P_C1        = 32'sd3038;
  localparam logic signed [31:0] P_C2        = -32'sd7357;
  localparam logic signed [31:0] P_C3        = 32'sd3791;

endpackage

>>> hw/rtl/bsc_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
module bsc_div #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [W-1:0]  quot,
  output logic [SW-1:0] side_out
);

  logic          v   [W];
  logic [W-1:0]  rem [W];
  logic [W-1:0]  n   [W];
  logic [W-1:0]  q   [W];
  logic [W-1:0]  d   [W];
  logic [SW-1:0] s   [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam int B = W - 1 - k;
    logic          iv;
    logic [W-1:0]  ir, in_, iq, id;
    logic [SW-1:0] is;
    logic [W:0]    trial, diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign iv  = in_valid;
      assign ir  = '0;
      assign in_ = num;
      assign iq  = '0;
      assign id  = den;
      assign is  = side_in;
    end else begin : g_next
      assign iv  = v[k-1];
      assign ir  = rem[k-1];
      assign in_ = n[k-1];
      assign iq  = q[k-1];
      assign id  = d[k-1];
      assign is  = s[k-1];
    end

    assign trial = {ir, in_[B]};
    assign diff  = trial - {1'b0, id};
    assign ge    = ~diff[W];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= iv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[W-1:0] : trial[W-1:0];
        n[k]   <= in_;
        q[k]   <= iq | ({{(W-1){1'b0}}, ge} << B);
        d[k]   <= id;
        s[k]   <= is;
      end
    end
  end

  assign out_valid = v[W-1];
  assign quot      = q[W-1];
  assign side_out  = s[W-1];

endmodule

>>> hw/rtl/bsc_regs.sv
// APB calibration register file.
module bsc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output bsc_pkg::cal_t              cal
);
  import bsc_pkg::*;

  logic [31:0] regs [REG_COUNT];
  logic [2:0]  idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) regs[i] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_AC1_AC2: regs[0] <= pwdata;
        REG_AC3_AC4: regs[1] <= pwdata;
        REG_AC5_AC6: regs[2] <= pwdata;
        REG_B1_B2:   regs[3] <= pwdata;
        REG_MC_MD:   regs[4] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AC1_AC2: prdata = regs[0];
      REG_AC3_AC4: prdata = regs[1];
      REG_AC5_AC6: prdata = regs[2];
      REG_B1_B2:   prdata = regs[3];
      REG_MC_MD:   prdata = regs[4];
      default:     prdata = '0;
    endcase
  end

  assign cal.ac1 = regs[0][31:16];
  assign cal.ac2 = regs[0][15:0];
  assign cal.ac3 = regs[1][31:16];
  assign cal.ac4 = regs[1][15:0];
  assign cal.ac5 = regs[2][31:16];
  assign cal.ac6 = regs[2][15:0];
  assign cal.b1  = regs[3][31:16];
  assign cal.b2  = regs[3][15:0];
  assign cal.mc  = regs[4][31:16];
  assign cal.md  = regs[4][15:0];

endmodule

>>> hw/rtl/barometric_sensor_compensation.sv
// Barometer compensation: temperature and pressure pipeline with APB calibration.
// Takes one raw sample word per cycle and returns one compensated word after
// two front stages, a 32-stage magnitude divider for the temperature term,
// six polynomial stages, a 32-stage unsigned divider for pressure and three
// output stages. When the output word is not taken the whole pipeline holds,
// and in_ready drops until it moves again. Calibration registers sit at byte
// offsets 0, 4, 8, 12 and 16 and must be written while no word is in flight.
module barometric_sensor_compensation (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bsc_pkg::in_word_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bsc_pkg::out_word_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import bsc_pkg::*;

  localparam int TSW = 60;
  localparam int PSW = 34;

  cal_t cal;
  logic adv;

  bsc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cal
  );

  assign adv      = ~out_valid | out_ready;
  assign in_ready = adv;

  logic signed [31:0] ac1_w, ac2_w, ac3_w, b1_w, b2_w, md_w;
  assign ac1_w = 32'(cal.ac1);
  assign ac2_w = 32'(cal.ac2);
  assign ac3_w = 32'(cal.ac3);
  assign b1_w  = 32'(cal.b1);
  assign b2_w  = 32'(cal.b2);
  assign md_w  = 32'(cal.md);

  // P1: (ut - ac6) * ac5
  logic               v1;
  logic signed [31:0] prod1;
  logic [23:0]        praw1;
  logic [1:0]         oss1;
  logic signed [17:0] utd;
  logic signed [35:0] prod_full;

  assign utd       = $signed({2'b0, in_data.raw_temp}) - $signed({2'b0, cal.ac6});
  assign prod_full = 36'(utd) * $signed({20'b0, cal.ac5});

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      prod1 <= prod_full[31:0];
      praw1 <= in_data.raw_press;
      oss1  <= in_data.oversampling;
    end
  end

  // P2: x1, divisor and numerator magnitudes
  logic signed [31:0] x1_c, rnd1, d_c, num_c;
  logic               v2, neg2, err2;
  logic signed [31:0] x1_2;
  logic [31:0]        nmag2, dmag2;
  logic [23:0]        praw2;
  logic [1:0]         oss2;

  assign rnd1  = prod1 + (prod1[31] ? 32'sd32767 : 32'sd0);
  assign x1_c  = rnd1 >>> 15;
  assign d_c   = x1_c + md_w;
  assign num_c = {{5{cal.mc[15]}}, cal.mc, 11'b0};

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      x1_2  <= x1_c;
      neg2  <= num_c[31] ^ d_c[31];
      err2  <= (d_c == 32'sd0);
      nmag2 <= num_c[31] ? 32'(-num_c) : num_c;
      dmag2 <= d_c[31] ? 32'(-d_c) : d_c;
      praw2 <= praw1;
      oss2  <= oss1;
    end
  end

  // Temperature divider
  logic           vt;
  logic [31:0]    qt;
  logic [TSW-1:0] st;

  bsc_div #(.W(32), .SW(TSW)) u_tdiv (
    .clk, .rst, .en(adv), .in_valid(v2), .num(nmag2), .den(dmag2),
    .side_in({x1_2, praw2, oss2, err2, neg2}),
    .out_valid(vt), .quot(qt), .side_out(st)
  );

  // P3: b5, temperature, b6
  logic signed [31:0] tx1, x2_c, b5_c, t8_c, tr_c;
  logic               v3, err3;
  logic signed [31:0] temp3, b6_3;
  logic [23:0]        praw3;
  logic [1:0]         oss3;

  assign tx1  = st[59:28];
  assign x2_c = st[0] ? 32'(-$signed(qt)) : $signed(qt);
  assign b5_c = tx1 + x2_c;
  assign t8_c = b5_c + 32'sd8;
  assign tr_c = t8_c + (t8_c[31] ? 32'sd15 : 32'sd0);

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= vt;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      temp3 <= tr_c >>> 4;
      b6_3  <= b5_c - TEMP_OFFSET;
      praw3 <= st[27:4];
      oss3  <= st[3:2];
      err3  <= st[1];
    end
  end

  // P4: b6 products
  logic               v4, err4;
  logic signed [31:0] b6sq4, ac2b6_4, ac3b6_4, temp4;
  logic [23:0]        praw4;
  logic [1:0]         oss4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b6sq4   <= b6_3 * b6_3;
      ac2b6_4 <= ac2_w * b6_3;
      ac3b6_4 <= ac3_w * b6_3;
      temp4   <= temp3;
      praw4   <= praw3;
      oss4    <= oss3;
      err4    <= err3;
    end
  end

  // P5: sq terms
  logic signed [31:0] sq_c;
  logic               v5, err5;
  logic signed [31:0] b2sq5, b1sq5, ac2b6_5, ac3b6_5, temp5;
  logic [23:0]        praw5;
  logic [1:0]         oss5;

  assign sq_c = b6sq4 >>> 12;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b2sq5   <= b2_w * sq_c;
      b1sq5   <= b1_w * sq_c;
      ac2b6_5 <= ac2b6_4;
      ac3b6_5 <= ac3b6_4;
      temp5   <= temp4;
      praw5   <= praw4;
      oss5    <= oss4;
      err5    <= err4;
    end
  end

  // P6: b3 and the b4 operand
  logic signed [31:0] x3a_c, s3_c, sh_c, x3b_c;
  logic               v6, err6;
  logic signed [31:0] b3_6, x3b_6, temp6;
  logic [23:0]        praw6;
  logic [1:0]         oss6;

  assign x3a_c = (b2sq5 >>> 11) + (ac2b6_5 >>> 11);
  assign s3_c  = (ac1_w <<< 2) + x3a_c;
  assign sh_c  = (s3_c << oss5) + 32'sd2;
  assign x3b_c = (ac3b6_5 >>> 13) + (b1sq5 >>> 16) + 32'sd2;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (adv) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b3_6  <= sh_c >>> 2;
      x3b_6 <= x3b_c >>> 2;
      temp6 <= temp5;
      praw6 <= praw5;
      oss6  <= oss5;
      err6  <= err5;
    end
  end

  // P7: b4 product and up - b3
  logic [31:0]        up_c;
  logic               v7, err7;
  logic [31:0]        b4p7, upd7;
  logic signed [31:0] temp7;
  logic [1:0]         oss7;

  assign up_c = {8'b0, praw6} >> (4'd8 - {2'b0, oss6});

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (adv) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b4p7  <= {16'b0, cal.ac4} * ($unsigned(x3b_6) + B4_BIAS);
      upd7  <= up_c - $unsigned(b3_6);
      temp7 <= temp6;
      oss7  <= oss6;
      err7  <= err6;
    end
  end

  // P8: b4 and b7
  logic [31:0]        b4_c;
  logic               v8, err8;
  logic [31:0]        b4_8, b7_8;
  logic signed [31:0] temp8;

  assign b4_c = b4p7 >> 15;

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (adv) v8 <= v7;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b4_8  <= b4_c;
      b7_8  <= upd7 * (B7_SCALE >> oss7);
      temp8 <= temp7;
      err8  <= err7 | (b4_c == 32'd0);
    end
  end

  // Pressure divider; large b7 divides first and doubles after
  logic           vp;
  logic [31:0]    qp;
  logic [PSW-1:0] sp;

  bsc_div #(.W(32), .SW(PSW)) u_pdiv (
    .clk, .rst, .en(adv), .in_valid(v8),
    .num(b7_8[31] ? b7_8 : {b7_8[30:0], 1'b0}), .den(b4_8),
    .side_in({temp8, err8, b7_8[31]}),
    .out_valid(vp), .quot(qp), .side_out(sp)
  );

  // P10: p and its products
  logic signed [31:0] p_c, t_c;
  logic               v10, err10;
  logic signed [31:0] p10, tt10, mp10, temp10;

  assign p_c = sp[0] ? $signed({qp[30:0], 1'b0}) : $signed(qp);
  assign t_c = p_c >>> 8;

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (adv) v10 <= vp;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p10    <= p_c;
      tt10   <= t_c * t_c;
      mp10   <= P_C2 * p_c;
      temp10 <= sp[33:2];
      err10  <= sp[1];
    end
  end

  // P11
  logic               v11, err11;
  logic signed [31:0] p11, x1m11, x2_11, temp11;

  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (adv) v11 <= v10;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p11    <= p10;
      x1m11  <= tt10 * P_C1;
      x2_11  <= mp10 >>> 16;
      temp11 <= temp10;
      err11  <= err10;
    end
  end

  // P12: output word register
  logic signed [31:0] press_c, sum_c;
  logic               v12;

  assign sum_c   = (x1m11 >>> 16) + x2_11 + P_C3;
  assign press_c = p11 + (sum_c >>> 4);

  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (adv) v12 <= v11;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.temperature <= err11 ? 32'sd0 : temp11;
      out_data.pressure    <= err11 ? 32'sd0 : press_c;
      out_data.div_error   <= err11;
    end
  end

  assign out_valid = v12;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.div_error |->
      out_data.temperature == 32'sd0 && out_data.pressure == 32'sd0)
    else $error("error word carries nonzero results");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({v1, v2, v3, v8, v10, v11}))
    else $error("pipeline moved during stall");

  a_bubble: assert property (@(posedge clk) disable iff (rst)
    adv && !in_valid |=> !v1)
    else $error("bubble did not enter pipeline");

endmodule

>>> tb/testbench.sv
// Testbench for barometric_sensor_compensation: scoreboard, drivers and checks.
`timescale 1ns / 1ps

class baro_scoreboard;
  logic [31:0] cal_word[bsc_pkg::REG_COUNT];
  bsc_pkg::out_word_t pending[$];
  int mismatches;
  int n_checked;
  int n_div_err;

  function new();
    foreach (cal_word[i]) cal_word[i] = '0;
    mismatches = 0;
    n_checked = 0;
    n_div_err = 0;
  endfunction

  // truncating divide, with the one overflow case pinned
  function int sdiv(int a, int b);
    if (a == 32'sh8000_0000 && b == -1) return a;
    return a / b;
  endfunction

  function bsc_pkg::out_word_t compensate(bsc_pkg::in_word_t w);
    bsc_pkg::out_word_t r;
    int ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
    int unsigned ac4, b4, b7, up, pu, sh;
    int ut, x1, x2, x3, d, b5, b6, sq, b3, p, t, temp_c;
    ac1 = int'($signed(cal_word[bsc_pkg::REG_AC1_AC2][31:16]));
    ac2 = int'($signed(cal_word[bsc_pkg::REG_AC1_AC2][15:0]));
    ac3 = int'($signed(cal_word[bsc_pkg::REG_AC3_AC4][31:16]));
    ac4 = {16'd0, cal_word[bsc_pkg::REG_AC3_AC4][15:0]};
    ac5 = int'({16'd0, cal_word[bsc_pkg::REG_AC5_AC6][31:16]});
    ac6 = int'({16'd0, cal_word[bsc_pkg::REG_AC5_AC6][15:0]});
    b1  = int'($signed(cal_word[bsc_pkg::REG_B1_B2][31:16]));
    b2  = int'($signed(cal_word[bsc_pkg::REG_B1_B2][15:0]));
    mc  = int'($signed(cal_word[bsc_pkg::REG_MC_MD][31:16]));
    md  = int'($signed(cal_word[bsc_pkg::REG_MC_MD][15:0]));
    r = '0;
    r.div_error = 1'b1;
    ut = int'({16'd0, w.raw_temp});
    x1 = sdiv((ut - ac6) * ac5, 32768);
    d = x1 + md;
    if (d == 0) return r;
    x2 = sdiv(mc * 2048, d);
    b5 = x1 + x2;
    temp_c = sdiv(b5 + 8, 16);
    b6 = b5 - bsc_pkg::TEMP_OFFSET;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    sh = (int'(ac1 * 4 + x3) << w.oversampling) + 32'd2;
    b3 = int'(sh) >>> 2;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    b4 = (ac4 * (int'(x3) + bsc_pkg::B4_BIAS)) >> 15;
    if (b4 == 0) return r;
    up = {8'd0, w.raw_press} >> (8 - w.oversampling);
    b7 = (up - b3) * (bsc_pkg::B7_SCALE >> w.oversampling);
    pu = (b7 < 32'h8000_0000) ? ((b7 << 1) / b4) : ((b7 / b4) << 1);
    p = int'(pu);
    t = p >>> 8;
    x1 = t * t;
    x1 = (x1 * bsc_pkg::P_C1) >>> 16;
    x2 = (bsc_pkg::P_C2 * p) >>> 16;
    r.temperature = temp_c;
    r.pressure = p + ((x1 + x2 + bsc_pkg::P_C3) >>> 4);
    r.div_error = 1'b0;
    return r;
  endfunction

  function void note_input(bsc_pkg::in_word_t w);
    pending.push_back(compensate(w));
  endfunction

  function void check_result(bsc_pkg::out_word_t got);
    bsc_pkg::out_word_t exp_w;
    if (pending.size() == 0) begin
      $error("result with nothing pending: temp %0d press %0d err %0b",
             got.temperature, got.pressure, got.div_error);
      mismatches++;
      return;
    end
    exp_w = pending.pop_front();
    n_checked++;
    if (exp_w.div_error) n_div_err++;
    if (got.temperature !== exp_w.temperature) begin
      $error("temperature: expected %0d, got %0d", exp_w.temperature, got.temperature);
      mismatches++;
    end
    if (got.pressure !== exp_w.pressure) begin
      $error("pressure: expected %0d, got %0d", exp_w.pressure, got.pressure);
      mismatches++;
    end
    if (got.div_error !== exp_w.div_error) begin
      $error("div_error: expected %0b, got %0b", exp_w.div_error, got.div_error);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  import bsc_pkg::*;

  localparam int MAX_CYCLES = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  baro_scoreboard sb = new();
  bit no_idle = 1'b0;
  int stall_left = 0;
  int cycles = 0;
  int n_sent = 0;

  barometric_sensor_compensation DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("** barometric_sensor_compensation: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_input(in_data);
  end

  // result sink with random stalls
  always @(posedge clk) begin : sink
    int n;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      sb.check_result(out_data);
      n = no_idle ? 0 : $urandom_range(0, 10);
      stall_left <= n;
      out_ready <= (n == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx)); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.cal_word[idx] = v;
  endtask

  task automatic send_word(in_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // stop sending and let the pipeline empty out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    w.oversampling = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: begin
        w.raw_temp = 16'($urandom);
        w.raw_press = 24'($urandom);
      end
      3: begin
        w.raw_temp = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 3));
        w.raw_press = $urandom_range(0, 1) ? 24'hFFFFFF : 24'($urandom_range(0, 255));
      end
      default: begin
        // plausible sensor readings
        w.raw_temp = 16'($urandom_range(15000, 40000));
        w.raw_press = 24'(($urandom_range(15000, 50000) << (8 - w.oversampling))
                          | $urandom_range(0, 255) >> w.oversampling);
      end
    endcase
    return w;
  endfunction

  logic [31:0] cal_sets[7][REG_COUNT] = '{
    '{32'h0198_FFB8, 32'hC7D1_7FE5, 32'h7FF5_5A71, 32'h182E_0004, 32'hDDF9_0B34},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000},
    '{32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF},
    '{32'h0198_FFB8, 32'hC7D1_0000, 32'h7FF5_5A71, 32'h182E_0004, 32'hDDF9_0B34},
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0}
  };

  initial begin
    in_word_t w;
    reg_idx_t idx;
    for (int s = 5; s < 7; s++)
      for (int i = 0; i < REG_COUNT; i++) cal_sets[s][i] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // calibration still at reset: every word hits the zero divisor
    for (int i = 0; i < 8; i++) send_word(random_word());
    drain();

    for (int s = 0; s < 7; s++) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        idx = reg_idx_t'(i);
        cfg_write(idx, cal_sets[s][i]);
      end
      if (s == 0) begin
        for (int o = 0; o < 4; o++) begin
          w.oversampling = 2'(o);
          w.raw_temp = 16'd27898; w.raw_press = 24'(23843 << (8 - o));
          send_word(w);
          w.raw_temp = 16'h0000; w.raw_press = 24'h000000;
          send_word(w);
          w.raw_temp = 16'hFFFF; w.raw_press = 24'hFFFFFF;
          send_word(w);
          w.raw_temp = 16'hFFFF; w.raw_press = 24'h000000;
          send_word(w);
          w.raw_temp = 16'h0000; w.raw_press = 24'hFFFFFF;
          send_word(w);
        end
      end
      for (int i = 0; i < 125; i++) begin
        if (i % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_word(random_word());
      end
      no_idle = 1'b0;
      drain();
    end

    $display("Sent %0d sample words over 8 calibration sets (reset, typical, extremes,",
             n_sent);
    $display("  random); checked %0d results, %0d with divide error.",
             sb.n_checked, sb.n_div_err);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("** barometric_sensor_compensation: PASSED **");
    end else begin
      $display("** barometric_sensor_compensation: FAILED **");
    end
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_div.sv
hw/rtl/bsc_regs.sv
hw/rtl/barometric_sensor_compensation.sv
tb/testbench.sv
